### rtl/core/aff_pkg.sv
// ----------------------------------------------------------------------------
// aff_pkg
// Shared types and constants for the affine matrix inverse pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aff_pkg;

    // Number of output coefficients, one divider lane each
    localparam int LANES = 6;
    // Quotient bits kept by a divider lane (32 bits plus one for range check)
    localparam int QW = 33;
    // Width of the determinant and adjugate terms
    localparam int DW = 64;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SINGULAR  = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

    // Sideband that travels with one divider lane
    typedef struct packed {
        logic valid;
        logic neg;
        logic tag;
    } div_ctl_t;

    // Sideband leaving one divider lane
    typedef struct packed {
        logic valid;
        logic sat;
        logic tag;
    } div_res_t;

    // Magnitude of a signed 64-bit value (the most negative value maps to 2^63)
    function automatic logic [DW-1:0] mag64(input logic signed [DW-1:0] v);
        logic [DW-1:0] r;
        r = v[DW-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

endpackage

### rtl/core/aff_front.sv
// ----------------------------------------------------------------------------
// aff_front
// Products, determinant and adjugate terms, then per-lane numerator and
// denominator magnitudes for the divider lanes. Three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aff_front #(
    parameter int FRAC_BITS = 16,
    parameter int NW        = 64 + 2 * FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [31:0]        a_in,
    input  logic signed [31:0]        b_in,
    input  logic signed [31:0]        c_in,
    input  logic signed [31:0]        d_in,
    input  logic signed [31:0]        tx_in,
    input  logic signed [31:0]        ty_in,
    output logic [NW-1:0]             num    [aff_pkg::LANES],
    output logic [aff_pkg::DW-1:0]    den,
    output aff_pkg::div_ctl_t         ctl    [aff_pkg::LANES]
);

    localparam int DW = aff_pkg::DW;

    // stage 1: the six products
    logic                 v1_reg;
    logic signed [DW-1:0] p_ad_reg, p_bc_reg, p_cty_reg, p_dtx_reg, p_btx_reg, p_aty_reg;
    logic signed [31:0]   a1_reg, b1_reg, c1_reg, d1_reg;

    // stage 2: determinant and translation terms
    logic                 v2_reg;
    logic signed [DW-1:0] det_reg, nx_reg, ny_reg;
    logic signed [31:0]   a2_reg, b2_reg, c2_reg, d2_reg;

    // stage 3: lane operands
    logic                 v3_reg;
    logic                 sing_reg;
    logic [NW-1:0]        num_reg [aff_pkg::LANES];
    logic [DW-1:0]        den_reg;
    logic                 neg_reg [aff_pkg::LANES];

    logic                 sing_next;
    logic signed [DW-1:0] term    [aff_pkg::LANES];
    logic                 flip    [aff_pkg::LANES];
    logic [NW-1:0]        num_next[aff_pkg::LANES];
    logic                 neg_next[aff_pkg::LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_ad_reg  <= DW'(a_in) * DW'(d_in);
        p_bc_reg  <= DW'(b_in) * DW'(c_in);
        p_cty_reg <= DW'(c_in) * DW'(ty_in);
        p_dtx_reg <= DW'(d_in) * DW'(tx_in);
        p_btx_reg <= DW'(b_in) * DW'(tx_in);
        p_aty_reg <= DW'(a_in) * DW'(ty_in);
        a1_reg    <= a_in;
        b1_reg    <= b_in;
        c1_reg    <= c_in;
        d1_reg    <= d_in;

        det_reg   <= p_ad_reg - p_bc_reg;
        nx_reg    <= p_cty_reg - p_dtx_reg;
        ny_reg    <= p_btx_reg - p_aty_reg;
        a2_reg    <= a1_reg;
        b2_reg    <= b1_reg;
        c2_reg    <= c1_reg;
        d2_reg    <= d1_reg;

        sing_reg  <= sing_next;
        den_reg   <= sing_next ? DW'(1) : aff_pkg::mag64(det_reg);
        for (int i = 0; i < aff_pkg::LANES; i++)
        begin
            num_reg[i] <= num_next[i];
            neg_reg[i] <= neg_next[i];
        end
    end

    // adjugate terms in output order; shears are negated
    always_comb
    begin
        sing_next = (det_reg == '0);
        term[0] = DW'(d2_reg);
        term[1] = DW'(b2_reg);
        term[2] = DW'(c2_reg);
        term[3] = DW'(a2_reg);
        term[4] = nx_reg;
        term[5] = ny_reg;
        flip[0] = 1'b0;
        flip[1] = 1'b1;
        flip[2] = 1'b1;
        flip[3] = 1'b0;
        flip[4] = 1'b0;
        flip[5] = 1'b0;
        for (int i = 0; i < aff_pkg::LANES; i++)
        begin
            // linear terms carry two fraction shifts, translations one
            if (i < 4)
                num_next[i] = NW'(aff_pkg::mag64(term[i])) << (2 * FRAC_BITS);
            else
                num_next[i] = NW'(aff_pkg::mag64(term[i])) << FRAC_BITS;
            if (sing_next)
                num_next[i] = '0;
            neg_next[i] = term[i][DW-1] ^ det_reg[DW-1] ^ flip[i];
        end
    end

    assign den = den_reg;

    always_comb
    begin
        for (int i = 0; i < aff_pkg::LANES; i++)
        begin
            num[i]       = num_reg[i];
            ctl[i].valid = v3_reg;
            ctl[i].neg   = neg_reg[i];
            ctl[i].tag   = sing_reg;
        end
    end

endmodule

### rtl/core/aff_div.sv
// ----------------------------------------------------------------------------
// aff_div
// Pipelined restoring divider, one quotient bit per stage. Range check up
// front, then QW bit stages, then signed saturation to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aff_div #(
    parameter int NW = 96
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [NW-1:0]             num,
    input  logic [aff_pkg::DW-1:0]    den,
    input  aff_pkg::div_ctl_t         ctl_in,
    output logic signed [31:0]        quo,
    output aff_pkg::div_res_t         res_out
);

    localparam int DW = aff_pkg::DW;
    localparam int QW = aff_pkg::QW;
    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    aff_pkg::div_ctl_t ctl_reg [QW+1];
    logic              ovf_reg [QW+1];
    logic [DW-1:0]     rem_reg [QW+1];
    logic [QW-1:0]     low_reg [QW+1];
    logic [QW-1:0]     q_reg   [QW+1];
    logic [DW-1:0]     den_reg [QW+1];

    logic [DW:0]       rem2    [QW];
    logic              ge      [QW];
    logic [DW-1:0]     rem_next[QW];

    aff_pkg::div_res_t res_reg;
    logic signed [31:0] quo_reg;
    logic               sat_next;
    logic signed [31:0] quo_next;
    logic [QW-1:0]      q_fin;

    // control travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                ctl_reg[k] <= '0;
            res_reg <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int k = 0; k < QW; k++)
                ctl_reg[k+1] <= ctl_reg[k];
            res_reg.valid <= ctl_reg[QW].valid;
            res_reg.tag   <= ctl_reg[QW].tag;
            res_reg.sat   <= sat_next;
        end
    end

    // one trial subtract per stage
    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            rem2[k]     = {rem_reg[k], low_reg[k][QW-1]};
            ge[k]       = rem2[k] >= {1'b0, den_reg[k]};
            rem_next[k] = ge[k] ? DW'(rem2[k] - {1'b0, den_reg[k]}) : DW'(rem2[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        // quotient at or above 2^QW saturates for sure
        ovf_reg[0] <= CW'(num[NW-1:QW]) >= CW'(den);
        rem_reg[0] <= DW'(num >> QW);
        low_reg[0] <= num[QW-1:0];
        q_reg[0]   <= '0;
        den_reg[0] <= den;
        for (int k = 0; k < QW; k++)
        begin
            ovf_reg[k+1] <= ovf_reg[k];
            rem_reg[k+1] <= rem_next[k];
            low_reg[k+1] <= low_reg[k] << 1;
            q_reg[k+1]   <= {q_reg[k][QW-2:0], ge[k]};
            den_reg[k+1] <= den_reg[k];
        end
        quo_reg <= quo_next;
    end

    // sign and saturate
    always_comb
    begin
        q_fin = q_reg[QW];
        if (ctl_reg[QW].neg)
            sat_next = ovf_reg[QW] || (q_fin > QW'(33'h0_8000_0000));
        else
            sat_next = ovf_reg[QW] || (q_fin > QW'(33'h0_7FFF_FFFF));
        if (sat_next)
            quo_next = ctl_reg[QW].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (ctl_reg[QW].neg)
            quo_next = -$signed(q_fin[31:0]);
        else
            quo_next = $signed(q_fin[31:0]);
    end

    assign quo     = quo_reg;
    assign res_out = res_reg;

endmodule

### rtl/core/affine_matrix_invert.sv
// ----------------------------------------------------------------------------
// affine_matrix_invert
// Inverse of a 2D affine matrix in signed fixed point, fully pipelined.
//
//   channel   handshake         fields
//   input     start / busy      m_xx m_yx m_xy m_yy m_tx m_ty
//   result    done (strobe)     inv_xx inv_yx inv_xy inv_yy inv_tx inv_ty
//                               result_status
//
// One item enters per cycle; busy is always low. The pipeline has three
// front stages (products, determinant, operands), QW+2 divider stages
// (range check, one quotient bit per stage, saturation, six lanes) and
// one output stage. Reset clears all valid bits; items in flight are
// dropped. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_matrix_invert #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] m_xx,
    input  logic signed [31:0] m_yx,
    input  logic signed [31:0] m_xy,
    input  logic signed [31:0] m_yy,
    input  logic signed [31:0] m_tx,
    input  logic signed [31:0] m_ty,
    output logic               done,
    output logic signed [31:0] inv_xx,
    output logic signed [31:0] inv_yx,
    output logic signed [31:0] inv_xy,
    output logic signed [31:0] inv_yy,
    output logic signed [31:0] inv_tx,
    output logic signed [31:0] inv_ty,
    output logic [1:0]         result_status
);

    localparam int NW  = 64 + 2 * FRAC_BITS;
    localparam int LAT = 3 + aff_pkg::QW + 2 + 1;

    logic [NW-1:0]          num  [aff_pkg::LANES];
    logic [aff_pkg::DW-1:0] den;
    aff_pkg::div_ctl_t      ctl  [aff_pkg::LANES];
    logic signed [31:0]     quo  [aff_pkg::LANES];
    aff_pkg::div_res_t      res  [aff_pkg::LANES];

    logic                   done_reg;
    aff_pkg::status_t       status_reg;
    aff_pkg::status_t       status_next;
    logic signed [31:0]     inv_reg [aff_pkg::LANES];
    logic                   any_sat;
    logic                   any_sing;

    assign busy = 1'b0;

    aff_front #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .a_in     (m_xx),
        .b_in     (m_yx),
        .c_in     (m_xy),
        .d_in     (m_yy),
        .tx_in    (m_tx),
        .ty_in    (m_ty),
        .num      (num),
        .den      (den),
        .ctl      (ctl)
    );

    for (genvar i = 0; i < aff_pkg::LANES; i++)
    begin : g_lane
        aff_div #(
            .NW (NW)
        ) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .num     (num[i]),
            .den     (den),
            .ctl_in  (ctl[i]),
            .quo     (quo[i]),
            .res_out (res[i])
        );
    end

    // status from lane flags
    always_comb
    begin
        any_sat  = 1'b0;
        any_sing = 1'b0;
        for (int i = 0; i < aff_pkg::LANES; i++)
        begin
            any_sat  = any_sat | res[i].sat;
            any_sing = any_sing | res[i].tag;
        end
        if (any_sing)
            status_next = aff_pkg::ST_SINGULAR;
        else if (any_sat)
            status_next = aff_pkg::ST_SATURATED;
        else
            status_next = aff_pkg::ST_OK;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= res[0].valid;
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        for (int i = 0; i < aff_pkg::LANES; i++)
            inv_reg[i] <= quo[i];
    end

    assign done          = done_reg;
    assign inv_xx        = inv_reg[0];
    assign inv_yx        = inv_reg[1];
    assign inv_xy        = inv_reg[2];
    assign inv_yy        = inv_reg[3];
    assign inv_tx        = inv_reg[4];
    assign inv_ty        = inv_reg[5];
    assign result_status = status_reg;

    // fixed latency from accept to result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after fixed latency");

    // a singular matrix gives an all-zero result
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_status == aff_pkg::ST_SINGULAR) |->
        (inv_xx == 0 && inv_yx == 0 && inv_xy == 0 && inv_yy == 0
         && inv_tx == 0 && inv_ty == 0))
        else $error("singular result not zero");

    // divider lanes 0 and 5, and lanes 1 and 4, stay in step
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (res[0].valid == res[5].valid) && (res[0].tag == res[5].tag)
        && (res[1].valid == res[4].valid))
        else $error("divider lanes out of step");

    // no result without an item accepted earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(start && !busy, LAT))
        else $error("result without item");

endmodule

### tb/affine_matrix_invert_checker.sv
// ----------------------------------------------------------------------------
// affine_matrix_invert_checker
// Watches the item and result channels of the affine inverse block, computes
// the expected inverse for each accepted item and compares every result
// field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_matrix_invert_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] m_xx,
    input  logic signed [31:0] m_yx,
    input  logic signed [31:0] m_xy,
    input  logic signed [31:0] m_yy,
    input  logic signed [31:0] m_tx,
    input  logic signed [31:0] m_ty,
    input  logic               done,
    input  logic signed [31:0] inv_xx,
    input  logic signed [31:0] inv_yx,
    input  logic signed [31:0] inv_xy,
    input  logic signed [31:0] inv_yy,
    input  logic signed [31:0] inv_tx,
    input  logic signed [31:0] inv_ty,
    input  logic [1:0]         result_status,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [31:0] xx, yx, xy, yy, tx, ty;
        aff_pkg::status_t   status;
    } inverse_t;

    inverse_t want_q[$];

    // Exact (num * 2^sh) / den, toward zero, with sign flip and 32-bit saturation
    function automatic logic signed [31:0] fixed_quot(input logic signed [127:0] num,
                                                     input int sh, input bit flip,
                                                     input logic signed [127:0] den,
                                                     inout bit sat);
        logic [127:0] nm, dm, q;
        bit neg;
        nm = num[127] ? -num : num;
        dm = den[127] ? -den : den;
        neg = (num[127] ^ den[127]) ^ flip;
        q = (nm << sh) / dm;
        if (!neg && q > 128'h7FFF_FFFF)
        begin
            sat = 1;
            return 32'sh7FFF_FFFF;
        end
        if (neg && q > 128'h8000_0000)
        begin
            sat = 1;
            return 32'sh8000_0000;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic inverse_t invert_affine(input logic signed [31:0] a, b, c, d, tx, ty);
        inverse_t r;
        bit sat;
        logic signed [127:0] det, nx, ny;
        r = '0;
        r.status = aff_pkg::ST_OK;
        sat = 0;
        if (b == 0 && c == 0)
        begin
            if (a == 0 || d == 0)
                r.status = aff_pkg::ST_SINGULAR;
            else
            begin
                r.xx = fixed_quot(1, 2*FRAC_BITS, 0, a, sat);
                r.yy = fixed_quot(1, 2*FRAC_BITS, 0, d, sat);
                r.tx = fixed_quot(tx, FRAC_BITS, 1, a, sat);
                r.ty = fixed_quot(ty, FRAC_BITS, 1, d, sat);
            end
        end
        else
        begin
            det = 128'(a) * 128'(d) - 128'(b) * 128'(c);
            if (det == 0)
                r.status = aff_pkg::ST_SINGULAR;
            else
            begin
                nx = 128'(c) * 128'(ty) - 128'(d) * 128'(tx);
                ny = 128'(b) * 128'(tx) - 128'(a) * 128'(ty);
                r.xx = fixed_quot(d, 2*FRAC_BITS, 0, det, sat);
                r.yx = fixed_quot(b, 2*FRAC_BITS, 1, det, sat);
                r.xy = fixed_quot(c, 2*FRAC_BITS, 1, det, sat);
                r.yy = fixed_quot(a, 2*FRAC_BITS, 0, det, sat);
                r.tx = fixed_quot(nx, FRAC_BITS, 0, det, sat);
                r.ty = fixed_quot(ny, FRAC_BITS, 0, det, sat);
            end
        end
        if (r.status == aff_pkg::ST_OK && sat)
            r.status = aff_pkg::ST_SATURATED;
        return r;
    endfunction

    task automatic cmp(input string nm, input logic [31:0] e, input logic [31:0] g);
        if (e !== g)
        begin
            fail_count++;
            $display("%0t mismatch %s: expected %h got %h", $time, nm, e, g);
        end
    endtask

    // Predict on accepted items, check on strobed results
    always @(posedge clk)
    begin
        inverse_t w;
        if (rst_n)
        begin
            if (done)
            begin
                if (want_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected result, nothing pending", $time);
                end
                else
                begin
                    w = want_q.pop_front();
                    cmp("inv_xx", w.xx, inv_xx);
                    cmp("inv_yx", w.yx, inv_yx);
                    cmp("inv_xy", w.xy, inv_xy);
                    cmp("inv_yy", w.yy, inv_yy);
                    cmp("inv_tx", w.tx, inv_tx);
                    cmp("inv_ty", w.ty, inv_ty);
                    cmp("result_status", 32'(w.status), 32'(result_status));
                end
            end
            if (start && !busy)
                want_q.push_back(invert_affine(m_xx, m_yx, m_xy, m_yy, m_tx, m_ty));
            pending = want_q.size();
        end
    end

endmodule

### tb/affine_matrix_invert_tb.sv
// ----------------------------------------------------------------------------
// affine_matrix_invert_tb
// Drives directed corner matrices, then random well-formed and extreme
// matrices through the affine inverse block with random sender gaps;
// a checker compares every result against its own prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_matrix_invert_tb;

    localparam int LATENCY   = 39;
    localparam int WDOG_MAX  = 5000;
    localparam int N_RANDOM  = 1200;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic clk = 0, rst_n = 0, start = 0;
    logic busy, done;
    logic signed [31:0] m_xx = 0, m_yx = 0, m_xy = 0, m_yy = 0, m_tx = 0, m_ty = 0;
    logic signed [31:0] inv_xx, inv_yx, inv_xy, inv_yy, inv_tx, inv_ty;
    logic [1:0] result_status;
    int fail_count, pending, idle_pct, quiet;

    always #1 clk = ~clk;

    affine_matrix_invert u_top (.*);
    affine_matrix_invert_checker u_chk (.*);

    // Watchdog: cycles with nothing accepted and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WDOG_MAX)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Pick one coefficient: extremes, zero, unit, small, mid-range or raw random
    function automatic logic [31:0] coef();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            3: return $urandom_range(0, 1) ? ONE : -ONE;
            4: return 32'($signed($urandom_range(0, 16))) - 8;
            5, 6: return 32'($signed($urandom_range(0, 32'h0008_0000))) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic [31:0] a, b, c, d, tx, ty);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 0;
            @(negedge clk);
        end
        start <= 1;
        m_xx <= a; m_yx <= b; m_xy <= c; m_yy <= d; m_tx <= tx; m_ty <= ty;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] a, b, c, d;
        idle_pct = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed corners
        send(ONE, 0, 0, ONE, 0, 0);
        send(ONE, 0, 0, ONE, 32'h7FFF_FFFF, 32'h8000_0000);
        send(0, 0, 0, ONE, 5, 5);
        send(ONE, 0, 0, 0, 5, 5);
        send(1, 0, 0, 1, 1, -1);
        send(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send(-ONE, 0, 0, 2*ONE, 3*ONE, -ONE);
        send(0, ONE, ONE, 0, ONE, 2*ONE);
        send(ONE, ONE, ONE, ONE, 1, 1);
        send(2*ONE, ONE, 4*ONE, 2*ONE, 0, 0);
        send(ONE, -ONE, ONE, ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000);
        send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000);
        send(0, 1, 0, 0, 0, 0);
        send(1, 0, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
             32'hAAAA_AAAA, 32'h5555_5555);

        // Drain fully once before the random part
        start <= 0;
        while (pending != 0) @(negedge clk);

        // Random phases: no idling, heavy sender idling, no sender idling again
        // (the receiver cannot stall), light idling
        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ((i * 4) / N_RANDOM)
                0: idle_pct = 0;
                1: idle_pct = 47;
                2: idle_pct = 0;
                default: idle_pct = 14;
            endcase
            a = coef(); b = coef(); c = coef(); d = coef();
            case ($urandom_range(0, 5))
                0:
                begin
                    b = 0; c = 0;                       // diagonal matrix
                end
                1:
                begin
                    c = 32'($signed(a) * $signed(d)); b = 1;
                end
                2:
                begin
                    b = a; c = d;                       // singular pair rows
                end
                default: ;
            endcase
            send(a, b, c, d, coef(), coef());
            if (i % 300 == 150)
            begin
                start <= 0;
                while (pending != 0) @(negedge clk);
            end
        end
        start <= 0;

        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/aff_pkg.sv
rtl/core/aff_front.sv
rtl/core/aff_div.sv
rtl/core/affine_matrix_invert.sv
tb/affine_matrix_invert_checker.sv
tb/affine_matrix_invert_tb.sv
